### src/mme_pkg.sv
// shared types and constants of the matrix multiply engine
`timescale 1ns / 1ps
package mme_pkg;

	// register file
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 5;
	localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;
	localparam logic [CFG_DAT_W-1:0] DIM_RESET  = 5'd16;

	// width of a clamped dimension, holds the largest supported matrix size
	localparam int DIM_W = 7;

	// item kinds
	localparam logic [1:0] KIND_LOAD_A = 2'd0;
	localparam logic [1:0] KIND_LOAD_B = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	// result status
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_MISMATCH = 2'd1;
	localparam logic [1:0] STATUS_RANGE    = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [3:0]         row_index;
		logic [3:0]         col_index;
		logic signed [15:0] element_value;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] product_value;
		logic [3:0]         out_row;
		logic [3:0]         out_col;
		logic [1:0]         status;
	} out_word_t;

	// sequencer to datapath controls
	typedef struct packed {
		logic clear;
		logic issue;
	} mac_ctl_t;

endpackage

### src/mme_ram.sv
// single write port, single registered read port element store
`timescale 1ns / 1ps
module mme_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 16,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/mme_mac.sv
// multiply-accumulate datapath with 32-bit saturation
`timescale 1ns / 1ps
module mme_mac #(
	parameter int MAX_DIM    = 16,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mme_pkg::mac_ctl_t     ctl,
	input  logic [ELEM_WIDTH-1:0] a_data,
	input  logic [ELEM_WIDTH-1:0] b_data,
	output logic                  busy,
	output logic signed [31:0]    sum
);
	import mme_pkg::*;

	localparam int PROD_W = 2 * ELEM_WIDTH;
	localparam int ACC_W  = PROD_W + $clog2(MAX_DIM + 1);
	localparam int SAT_W  = (ACC_W > 33) ? ACC_W : 33;
	localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sh0000_0000_7FFF_FFFF);
	localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-64'sh0000_0000_8000_0000);

	logic                     vld_s1;
	logic                     vld_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [SAT_W-1:0]  acc_x;

	// valid follows the store read latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(a_data) * $signed(b_data);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign acc_x = SAT_W'(acc_q);
	assign busy  = vld_s1 | vld_s2;

	always_comb begin
		if (acc_x > SAT_MAX) begin
			sum = 32'sh7FFF_FFFF;
		end else if (acc_x < SAT_MIN) begin
			sum = 32'sh8000_0000;
		end else begin
			sum = acc_x[31:0];
		end
	end

endmodule

### src/matrix_multiply_engine.sv
// matrix multiply engine top: element stores, read sequencer, output register
// a load word is written to its store at the edge that takes it
// a read that walks answers once its walk drains through the accumulator, when the output is free
// an error read or an empty inner dimension skips the walk and answers from the drain state
// a read holds the input from its take until its result is loaded into the output register,
// through the one-element-a-cycle store walk, and longer while the output word is stalled
// reset: dimension registers to 16 and all control cleared; store contents undefined
`timescale 1ns / 1ps
module matrix_multiply_engine #(
	parameter int MAX_DIM    = 16,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  mme_pkg::in_word_t                in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output mme_pkg::out_word_t               out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mme_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mme_pkg::CFG_DAT_W-1:0]    cfg_data
);
	import mme_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t state_q;

	// dimension registers
	logic [CFG_DAT_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [DIM_W-1:0]     ar_eff, ac_eff, br_eff, bc_eff;

	// read in flight
	logic [3:0]       row_q, col_q;
	logic [1:0]       status_q;
	logic [DIM_W-1:0] k_q;

	// output register
	logic      out_valid_q;
	out_word_t out_q;

	logic                  in_take, out_take, load_out;
	logic                  a_we, b_we;
	logic [AW-1:0]         waddr, a_raddr, b_raddr;
	logic [ELEM_WIDTH-1:0] wdata, a_rdata, b_rdata;
	logic [3:0]            rq_row, rq_col;
	logic                  rq_range, rq_mismatch;
	logic [1:0]            rq_status;
	mac_ctl_t              mac_ctl;
	logic                  mac_busy;
	logic signed [31:0]    mac_sum;

	// config port is always ready; writes must come only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= DIM_RESET;
			a_cols_q <= DIM_RESET;
			b_rows_q <= DIM_RESET;
			b_cols_q <= DIM_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_A_ROWS: a_rows_q <= cfg_data;
				REG_A_COLS: a_cols_q <= cfg_data;
				REG_B_ROWS: b_rows_q <= cfg_data;
				REG_B_COLS: b_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sizes above the store dimension act as the store dimension
	assign ar_eff = (DIM_W'(a_rows_q) > DIM_MAX) ? DIM_MAX : DIM_W'(a_rows_q);
	assign ac_eff = (DIM_W'(a_cols_q) > DIM_MAX) ? DIM_MAX : DIM_W'(a_cols_q);
	assign br_eff = (DIM_W'(b_rows_q) > DIM_MAX) ? DIM_MAX : DIM_W'(b_rows_q);
	assign bc_eff = (DIM_W'(b_cols_q) > DIM_MAX) ? DIM_MAX : DIM_W'(b_cols_q);

	// input side: loads and reads are taken only between reads
	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign rq_row   = in_data.row_index;
	assign rq_col   = in_data.col_index;

	// loads outside the configured size are dropped
	assign a_we = in_take && (in_data.kind == KIND_LOAD_A)
		&& (DIM_W'(rq_row) < ar_eff) && (DIM_W'(rq_col) < ac_eff);
	assign b_we = in_take && (in_data.kind == KIND_LOAD_B)
		&& (DIM_W'(rq_row) < br_eff) && (DIM_W'(rq_col) < bc_eff);
	assign waddr = AW'(int'(rq_row) * MAX_DIM + int'(rq_col));
	// cut to the element width with sign
	assign wdata = ELEM_WIDTH'(in_data.element_value);

	// read status, range takes priority over the inner dimension check
	assign rq_range    = (DIM_W'(rq_row) >= ar_eff) || (DIM_W'(rq_col) >= bc_eff);
	assign rq_mismatch = (ac_eff != br_eff);
	always_comb begin
		if (rq_range) begin
			rq_status = STATUS_RANGE;
		end else if (rq_mismatch) begin
			rq_status = STATUS_MISMATCH;
		end else begin
			rq_status = STATUS_OK;
		end
	end

	// walk row of a and column of b, one element pair a cycle
	assign a_raddr = AW'(int'(row_q) * MAX_DIM + int'(k_q));
	assign b_raddr = AW'(int'(k_q) * MAX_DIM + int'(col_q));

	assign mac_ctl.clear = in_take && (in_data.kind == KIND_READ);
	assign mac_ctl.issue = (state_q == ST_RUN);

	// result may load while the previous word leaves
	assign out_take = out_valid_q && !out_stall;
	assign load_out = (state_q == ST_DRAIN) && !mac_busy && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (in_take && (in_data.kind == KIND_READ)) begin
						// error reads and an empty inner dimension skip the walk
						if ((rq_status == STATUS_OK) && (ac_eff != '0)) begin
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_RUN: begin
					k_q <= k_q + DIM_W'(1);
					if (k_q == ac_eff - DIM_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request fields held for the answer
	always_ff @(posedge clk) begin
		if (in_take && (in_data.kind == KIND_READ)) begin
			row_q    <= rq_row;
			col_q    <= rq_col;
			status_q <= rq_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// accumulator is cleared at the read and untouched on error, so errors give zero
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.product_value <= mac_sum;
			out_q.out_row       <= row_q;
			out_q.out_col       <= col_q;
			out_q.status        <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	mme_ram #(
		.DEPTH (DEPTH),
		.WIDTH (ELEM_WIDTH),
		.AW    (AW)
	) u_a_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	mme_ram #(
		.DEPTH (DEPTH),
		.WIDTH (ELEM_WIDTH),
		.AW    (AW)
	) u_b_store (
		.clk   (clk),
		.we    (b_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	mme_mac #(
		.MAX_DIM    (MAX_DIM),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a_data (a_rdata),
		.b_data (b_rdata),
		.busy   (mac_busy),
		.sum    (mac_sum)
	);

endmodule

### tb/mme_tb_pkg.sv
// scoreboard of the matrix multiply engine bench: store mirror, product prediction, result checks
`timescale 1ns / 1ps
package mme_tb_pkg;
	import mme_pkg::*;

	localparam int DIM_MAX = 16;
	// kind code the block has no use for
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	class product_scoreboard;
		logic signed [15:0] a_elem [DIM_MAX*DIM_MAX];
		logic signed [15:0] b_elem [DIM_MAX*DIM_MAX];
		bit a_known [DIM_MAX*DIM_MAX];
		bit b_known [DIM_MAX*DIM_MAX];
		logic [CFG_DAT_W-1:0] a_rows, a_cols, b_rows, b_cols;
		out_word_t expected_products [$];
		int errors;

		function new();
			a_rows = DIM_RESET;
			a_cols = DIM_RESET;
			b_rows = DIM_RESET;
			b_cols = DIM_RESET;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				REG_A_ROWS: a_rows = val;
				REG_A_COLS: a_cols = val;
				REG_B_ROWS: b_rows = val;
				REG_B_COLS: b_cols = val;
				default: ;
			endcase
		endfunction

		// sizes above the store act as the full store
		function int dim(logic [CFG_DAT_W-1:0] v);
			return (v > DIM_MAX) ? DIM_MAX : int'(v);
		endfunction

		// returns 1 for a word that loads an element or asks for a product
		function bit note_input(in_word_t w);
			int r, c;
			longint acc;
			out_word_t e;
			r = w.row_index;
			c = w.col_index;
			case (w.kind)
				KIND_LOAD_A: begin
					if (r < dim(a_rows) && c < dim(a_cols)) begin
						a_elem[r*DIM_MAX+c] = w.element_value;
						a_known[r*DIM_MAX+c] = 1'b1;
						return 1'b1;
					end
					return 1'b0;
				end
				KIND_LOAD_B: begin
					if (r < dim(b_rows) && c < dim(b_cols)) begin
						b_elem[r*DIM_MAX+c] = w.element_value;
						b_known[r*DIM_MAX+c] = 1'b1;
						return 1'b1;
					end
					return 1'b0;
				end
				KIND_READ: begin
					acc = 0;
					e.out_row = w.row_index;
					e.out_col = w.col_index;
					e.status = STATUS_OK;
					if (r >= dim(a_rows) || c >= dim(b_cols)) begin
						e.status = STATUS_RANGE;
					end else if (dim(a_cols) != dim(b_rows)) begin
						e.status = STATUS_MISMATCH;
					end else begin
						// exact signed integer sum, then clamp to 32 bits
						for (int k = 0; k < dim(a_cols); k++)
							acc += longint'(a_elem[r*DIM_MAX+k]) * longint'(b_elem[k*DIM_MAX+c]);
						if (acc > 64'sd2147483647)
							acc = 64'sd2147483647;
						if (acc < -64'sd2147483648)
							acc = -64'sd2147483648;
					end
					e.product_value = acc[31:0];
					expected_products = {expected_products, e};
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			if (expected_products.size() == 0) begin
				$error("result with none expected: row %0d col %0d", got.out_row, got.out_col);
				errors++;
				return;
			end
			want = expected_products.pop_front();
			if (got.product_value !== want.product_value) begin
				$error("product_value: expected %0d, got %0d", want.product_value,
					got.product_value);
				errors++;
			end
			if (got.out_row !== want.out_row) begin
				$error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
				errors++;
			end
			if (got.out_col !== want.out_col) begin
				$error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
		endfunction

		function int pending();
			return expected_products.size();
		endfunction
	endclass

endpackage

### tb/testbench.sv
// top of the matrix multiply engine bench: clock, reset, drivers, monitors and test phases
`timescale 1ns / 1ps
module testbench;
	import mme_pkg::*;
	import mme_tb_pkg::*;

	localparam int RESET_CYCLES    = 10;
	localparam int QUIET_LIMIT     = 4000;   // cycles with no handshake at all
	localparam int HOLD_OFF_CYCLES = 400;    // one long output stall to back the block up
	localparam int SETTLE_CYCLES   = 24;     // margin for the longest read, which holds the input through its walk
	localparam int PHASE_ITEMS     = 190;
	localparam int NUM_PHASES      = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	product_scoreboard sb = new();

	// percentages of idle cycles on each side, changed per phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_off_req = 1'b0;
	// words that really load an element or ask for a product
	int useful_words = 0;

	always #5 clk = ~clk;

	matrix_multiply_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// receiving side: random stall, plus one long hold-off when asked
	initial begin : result_sink
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_done) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// handshake signals are steady from the falling edge to the next rising edge,
	// so what is seen here is what the block takes at that rising edge
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// watchdog: too long without any word moving on any channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

	// offer one input word, after random idle cycles; valid stays up on return
	// so that back-to-back words never drop it
	task automatic send_word(logic [1:0] kind, int r, int c, logic signed [15:0] v);
		in_word_t w;
		bit taken;
		w.kind = kind;
		w.row_index = 4'(r);
		w.col_index = 4'(c);
		w.element_value = v;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			if (!in_stall) begin
				taken = 1'b1;
				if (sb.note_input(w))
					useful_words++;
			end
			@(posedge clk);
		end
	endtask

	// write all four size registers, only while the block is idle
	task automatic set_dims(logic [CFG_DAT_W-1:0] ar, logic [CFG_DAT_W-1:0] ac,
			logic [CFG_DAT_W-1:0] br, logic [CFG_DAT_W-1:0] bc);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [CFG_DAT_W-1:0] vals [4];
		bit taken;
		idx = '{REG_A_ROWS, REG_A_COLS, REG_B_ROWS, REG_B_COLS};
		vals = '{ar, ac, br, bc};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			taken = 1'b0;
			while (!taken) begin
				@(negedge clk);
				if (cfg_ready) begin
					taken = 1'b1;
					sb.write_reg(idx[i], vals[i]);
				end
				@(posedge clk);
			end
		end
		cfg_valid <= 1'b0;
	endtask

	// drop valid, wait for every product, then let a last read work its way out
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// element values lean toward the extremes so sums saturate now and then
	function automatic logic signed [15:0] pick_element();
		case ($urandom_range(19))
			0, 1, 2: return 16'sh8000;
			3, 4, 5: return 16'sh7fff;
			6:       return 16'sh0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly inside the configured size, sometimes anywhere in the index range
	function automatic int pick_index(int n);
		if (n == 0 || $urandom_range(7) == 0)
			return $urandom_range(15);
		return $urandom_range(n - 1);
	endfunction

	// a read that will walk the stores gets its missing elements loaded first,
	// so no never-written entry is ever used
	task automatic read_product(int r, int c);
		int ar, ac, br, bc;
		ar = sb.dim(sb.a_rows);
		ac = sb.dim(sb.a_cols);
		br = sb.dim(sb.b_rows);
		bc = sb.dim(sb.b_cols);
		if (r < ar && c < bc && ac == br) begin
			for (int k = 0; k < ac; k++) begin
				if (!sb.a_known[r*DIM_MAX+k])
					send_word(KIND_LOAD_A, r, k, pick_element());
				if (!sb.b_known[k*DIM_MAX+c])
					send_word(KIND_LOAD_B, k, c, pick_element());
			end
		end
		// element field is don't-care on reads, so fill it with noise
		send_word(KIND_READ, r, c, 16'($urandom));
	endtask

	// one random step: a read, a load, or an unused kind
	task automatic random_word();
		int sel;
		sel = $urandom_range(99);
		if (sel < 55) begin
			read_product(pick_index(sb.dim(sb.a_rows)), pick_index(sb.dim(sb.b_cols)));
		end else if (sel < 95) begin
			if ($urandom_range(1))
				send_word(KIND_LOAD_A, pick_index(sb.dim(sb.a_rows)),
					pick_index(sb.dim(sb.a_cols)), pick_element());
			else
				send_word(KIND_LOAD_B, pick_index(sb.dim(sb.b_rows)),
					pick_index(sb.dim(sb.b_cols)), pick_element());
		end else begin
			send_word(KIND_UNUSED, $urandom_range(15), $urandom_range(15), 16'($urandom));
		end
	endtask

	initial begin : stimulus
		logic [CFG_DAT_W-1:0] plan [NUM_PHASES][4];
		int send_plan [NUM_PHASES];
		int recv_plan [NUM_PHASES];
		int target;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 2x3 times 3x2, short enough to hand-check
		set_dims(5'd2, 5'd3, 5'd3, 5'd2);
		for (int k = 0; k < 3; k++) begin
			send_word(KIND_LOAD_A, 0, k, 16'sh8000);
			send_word(KIND_LOAD_B, k, 0, 16'sh8000);
			send_word(KIND_LOAD_B, k, 1, 16'sh7fff);
		end
		// most negative squared three times runs past the top
		send_word(KIND_READ, 0, 0, 16'sh0000);
		// most negative times most positive three times runs past the bottom
		send_word(KIND_READ, 0, 1, 16'shffff);
		// loads outside the configured sizes are dropped
		send_word(KIND_LOAD_A, 2, 0, 16'sh1234);
		send_word(KIND_LOAD_B, 0, 2, 16'sh1234);
		// reads outside the product size report a range error
		send_word(KIND_READ, 2, 0, 16'sh0000);
		send_word(KIND_READ, 0, 15, 16'sh0000);
		send_word(KIND_UNUSED, 15, 15, 16'sh7fff);
		send_word(KIND_LOAD_A, 1, 0, 16'sh7fff);
		send_word(KIND_LOAD_A, 1, 1, 16'sh0000);
		send_word(KIND_LOAD_A, 1, 2, 16'sh0001);
		send_word(KIND_READ, 1, 0, 16'sh0000);
		send_word(KIND_READ, 1, 1, 16'sh0000);
		settle();

		// sizes per phase: full, beyond range, mismatch, empty inner, minimal,
		// no rows of a, clamped to full, two random settings, then full again
		plan = '{
			'{5'd16, 5'd16, 5'd16, 5'd16},
			'{5'd31, 5'd31, 5'd31, 5'd31},
			'{5'd4,  5'd3,  5'd5,  5'd6},
			'{5'd5,  5'd0,  5'd0,  5'd7},
			'{5'd1,  5'd1,  5'd1,  5'd1},
			'{5'd0,  5'd9,  5'd9,  5'd12},
			'{5'd16, 5'd17, 5'd20, 5'd16},
			'{5'd0,  5'd0,  5'd0,  5'd0},
			'{5'd0,  5'd0,  5'd0,  5'd0},
			'{5'd16, 5'd16, 5'd16, 5'd16}
		};
		for (int i = 0; i < 4; i++) begin
			plan[7][i] = CFG_DAT_W'($urandom_range(31));
			plan[8][i] = CFG_DAT_W'($urandom_range(31));
		end
		// the first random phase's inner pair matches most of the time
		if ($urandom_range(3) != 0)
			plan[7][2] = plan[7][1];
		send_plan = '{0, 75, 0, 32, 0, 75, 0, 32, 0, 32};
		recv_plan = '{0, 0, 75, 32, 0, 0, 75, 32, 0, 32};

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_dims(plan[p][0], plan[p][1], plan[p][2], plan[p][3]);
			send_idle_pct = send_plan[p];
			recv_stall_pct <= recv_plan[p];
			// first phase: long output hold-off while words keep coming
			if (p == 0)
				hold_off_req <= 1'b1;
			target = useful_words + PHASE_ITEMS;
			while (useful_words < target)
				random_word();
			settle();
		end

		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
